// ===== rtl/excess128_to_mulaw_resampler_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the resampler checkers.
// ----------------------------------------------------------------------------
`ifndef EXCESS128_TO_MULAW_RESAMPLER_MACROS_SVH
`define EXCESS128_TO_MULAW_RESAMPLER_MACROS_SVH

// Property checked only while out of reset.
`define E128M_ASSERT_RST(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Property checked on every edge, reset included.
`define E128M_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== rtl/e128m_pkg.sv =====
// ----------------------------------------------------------------------------
// e128m_pkg
// Types, constants and segment tables for the excess-128 to mu-law resampler.
// ----------------------------------------------------------------------------
package e128m_pkg;

    localparam int FRACTION_BITS     = 16;
    localparam int INC_W             = 20;
    localparam int DATA_W            = 8;
    localparam int RESET_IN_RATE     = 11000;
    localparam int OUT_RATE          = 8000;
    localparam int RUN_CAP           = 64;
    localparam int CNT_W             = $clog2(RUN_CAP);
    localparam int MAG_W             = 13;

    // upper bound (exclusive) of each segment's magnitude
    localparam logic [MAG_W-1:0] SEG_TOP [8] = '{
        13'd32, 13'd96, 13'd224, 13'd480, 13'd992, 13'd2016, 13'd4064, 13'd8160
    };
    // lower bound of each segment's magnitude
    localparam logic [MAG_W-1:0] SEG_BASE [8] = '{
        13'd0, 13'd32, 13'd96, 13'd224, 13'd480, 13'd992, 13'd2016, 13'd4064
    };

    localparam logic [DATA_W-1:0] CODE_CLIP = 8'h80;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SUB,
        ST_ADD,
        ST_OUT
    } state_t;

    typedef enum logic [1:0] {
        ACC_NONE,
        ACC_SUB,
        ACC_ADD
    } acc_op_t;

    typedef struct packed {
        logic le_zero;   // adder result <= 0
    } acc_stat_t;

endpackage

// ===== rtl/e128m_enc.sv =====
// ----------------------------------------------------------------------------
// e128m_enc
// Segmented mu-law encoder for one excess-128 byte.
// ----------------------------------------------------------------------------
module e128m_enc (
    input  logic [e128m_pkg::DATA_W-1:0] sample_byte,
    output logic [e128m_pkg::DATA_W-1:0] ulaw_code
);

    always_comb begin
        logic signed [8:0]               diff;
        logic                            neg;
        logic [7:0]                      mag_b;
        logic [e128m_pkg::MAG_W-1:0]     mag;
        logic [e128m_pkg::MAG_W-1:0]     rel;
        logic [e128m_pkg::MAG_W-1:0]     q;
        logic [2:0]                      seg;
        logic                            found;
        logic [e128m_pkg::DATA_W-1:0]    code;

        diff  = 9'sd128 - signed'({1'b0, sample_byte});
        neg   = diff[8];
        mag_b = neg ? 8'(-diff) : diff[7:0];
        mag   = {1'b0, mag_b, 4'b0000};

        found = 1'b0;
        seg   = 3'd0;
        for (int s = 0; s < 8; s++) begin
            if (!found && (mag < e128m_pkg::SEG_TOP[s])) begin
                found = 1'b1;
                seg   = 3'(s);
            end
        end

        // step of segment s is 2 << s
        rel  = mag - e128m_pkg::SEG_BASE[seg];
        q    = rel >> ({1'b0, seg} + 4'd1);
        code = found ? {4'hF - {1'b0, seg}, 4'hF - q[3:0]} : e128m_pkg::CODE_CLIP;
        if (neg) begin
            code[7] = 1'b0;
        end
        ulaw_code = code;
    end

endmodule

// ===== rtl/e128m_acc.sv =====
// ----------------------------------------------------------------------------
// e128m_acc
// Rate accumulator with its single shared adder: subtract one, add increment.
// ----------------------------------------------------------------------------
module e128m_acc #(
    parameter int FRACTION_BITS = e128m_pkg::FRACTION_BITS,
    parameter int ACC_W         = e128m_pkg::INC_W + 2
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  e128m_pkg::acc_op_t            op,
    input  logic [e128m_pkg::INC_W-1:0]   rate_increment,
    output e128m_pkg::acc_stat_t          stat
);

    localparam int IW = e128m_pkg::INC_W;
    localparam logic signed [ACC_W-1:0] ONE_Q =
        {{(ACC_W-1){1'b0}}, 1'b1} << FRACTION_BITS;
    localparam logic [IW-1:0] MIN_INC = {{(IW-1){1'b0}}, 1'b1} << (FRACTION_BITS - 6);

    logic signed [ACC_W-1:0] acc_reg;
    logic signed [ACC_W-1:0] acc_next;
    logic signed [ACC_W-1:0] operand;
    logic signed [ACC_W-1:0] sum;
    logic        [IW-1:0]    inc_eff;

    // clamp small increments so a run never exceeds the cap
    assign inc_eff = (rate_increment < MIN_INC) ? MIN_INC : rate_increment;

    always_comb begin
        case (op)
            e128m_pkg::ACC_SUB: operand = -ONE_Q;
            e128m_pkg::ACC_ADD: operand = signed'({{(ACC_W-IW){1'b0}}, inc_eff});
            default:            operand = '0;
        endcase
        sum      = acc_reg + operand;
        acc_next = (op == e128m_pkg::ACC_NONE) ? acc_reg : sum;
    end

    assign stat.le_zero = sum[ACC_W-1] || (sum == '0);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg <= ONE_Q;
        end else begin
            acc_reg <= acc_next;
        end
    end

endmodule

// ===== rtl/e128m_ctrl.sv =====
// ----------------------------------------------------------------------------
// e128m_ctrl
// Sequencer: takes a word, steps the accumulator and issues the repeats.
// ----------------------------------------------------------------------------
module e128m_ctrl (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [e128m_pkg::DATA_W-1:0]  enc_code,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [e128m_pkg::DATA_W-1:0]  m_tdata,
    output logic                          m_tlast,
    output e128m_pkg::acc_op_t            op,
    input  e128m_pkg::acc_stat_t          stat
);

    localparam int CW = e128m_pkg::CNT_W;

    e128m_pkg::state_t              state_reg, state_next;
    logic [e128m_pkg::DATA_W-1:0]   code_reg, code_next;
    logic                           last_reg, last_next;
    logic [CW-1:0]                  cnt_reg, cnt_next;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            e128m_pkg::ST_IDLE: if (s_tvalid) state_next = e128m_pkg::ST_SUB;
            e128m_pkg::ST_SUB: begin
                state_next = stat.le_zero ? e128m_pkg::ST_ADD : e128m_pkg::ST_IDLE;
            end
            e128m_pkg::ST_ADD:  state_next = e128m_pkg::ST_OUT;
            e128m_pkg::ST_OUT: begin
                if (m_tready) begin
                    state_next = last_reg ? e128m_pkg::ST_IDLE : e128m_pkg::ST_ADD;
                end
            end
            default:            state_next = e128m_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        s_tready = 1'b0;
        m_tvalid = 1'b0;
        op       = e128m_pkg::ACC_NONE;
        case (state_reg)
            e128m_pkg::ST_IDLE: s_tready = 1'b1;
            e128m_pkg::ST_SUB:  op       = e128m_pkg::ACC_SUB;
            e128m_pkg::ST_ADD:  op       = e128m_pkg::ACC_ADD;
            e128m_pkg::ST_OUT:  m_tvalid = 1'b1;
            default:            op       = e128m_pkg::ACC_NONE;
        endcase
    end

    always_comb begin
        code_next = code_reg;
        last_next = last_reg;
        cnt_next  = cnt_reg;
        if (state_reg == e128m_pkg::ST_IDLE && s_tvalid) begin
            code_next = enc_code;
            cnt_next  = '0;
        end
        if (state_reg == e128m_pkg::ST_ADD) begin
            // end the run once the accumulator turns positive or the cap is hit
            last_next = !stat.le_zero || (cnt_reg == {CW{1'b1}});
            cnt_next  = cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= e128m_pkg::ST_IDLE;
            cnt_reg   <= '0;
            last_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            last_reg  <= last_next;
        end
    end

    always_ff @(posedge aclk) begin
        code_reg <= code_next;
    end

    assign m_tdata = code_reg;
    assign m_tlast = last_reg;

endmodule

// ===== rtl/excess128_to_mulaw_resampler.sv =====
// ----------------------------------------------------------------------------
// excess128_to_mulaw_resampler
// Excess-128 bytes in, segmented mu-law codes out, resampled to 8000/s.
// ----------------------------------------------------------------------------
//  channel   direction  tdata                    tlast
//  s_        in         [7:0] sample_byte        -
//  m_        out        [7:0] ulaw_code          last_of_run
//  cfg_wr_   in         [19:0] rate_increment    -
//
//  A word passes ST_IDLE and ST_SUB (subtract one); if the sum is positive it
//  is dropped, else each repeat is ST_ADD then ST_OUT, which stalls on m_.
//  s_tready is high only while idle; no new word enters during a run.
//  Reset (synchronous, active low) sets the accumulator to 1.0 and the
//  increment to 11000/8000.
// ----------------------------------------------------------------------------
module excess128_to_mulaw_resampler #(
    parameter int FRACTION_BITS = e128m_pkg::FRACTION_BITS
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [7:0]                    s_tdata,     // [7:0] sample_byte
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [7:0]                    m_tdata,     // [7:0] ulaw_code
    output logic                          m_tlast,
    input  logic                          cfg_wr_en,
    input  logic [e128m_pkg::INC_W-1:0]   cfg_wr_data  // [19:0] rate_increment
);

    localparam int IW    = e128m_pkg::INC_W;
    localparam int ACC_W = ((FRACTION_BITS > IW) ? FRACTION_BITS : IW) + 2;
    localparam longint RESET_FULL =
        (longint'(e128m_pkg::RESET_IN_RATE) << FRACTION_BITS) / e128m_pkg::OUT_RATE;
    localparam logic [IW-1:0] RESET_INC = RESET_FULL[IW-1:0];

    logic [IW-1:0]                 inc_reg;
    logic [e128m_pkg::DATA_W-1:0]  enc_code;
    e128m_pkg::acc_op_t            op;
    e128m_pkg::acc_stat_t          stat;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            inc_reg <= RESET_INC;
        end else if (cfg_wr_en) begin
            inc_reg <= cfg_wr_data;
        end
    end

    e128m_enc u_enc (
        .sample_byte (s_tdata),
        .ulaw_code   (enc_code)
    );

    e128m_acc #(
        .FRACTION_BITS (FRACTION_BITS),
        .ACC_W         (ACC_W)
    ) u_acc (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .op             (op),
        .rate_increment (inc_reg),
        .stat           (stat)
    );

    e128m_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .enc_code (enc_code),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .op       (op),
        .stat     (stat)
    );

endmodule

// ===== rtl/e128m_checker.sv =====
// ----------------------------------------------------------------------------
// e128m_checker
// Port-level checks on the resampler, bound to the top level.
// ----------------------------------------------------------------------------
`include "excess128_to_mulaw_resampler_macros.svh"

module e128m_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_tvalid,
    input logic       s_tready,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic       m_tlast
);

    // input side and output side are never open together
    `E128M_ASSERT_RST(a_excl, aclk, aresetn, !(s_tready && m_tvalid), "s_tready with m_tvalid")

    // a taken word closes the input in the following cycle
    `E128M_ASSERT_RST(a_busy, aclk, aresetn, (s_tvalid && s_tready) |=> !s_tready, "ready after accept")

    // a stalled output word holds
    `E128M_ASSERT_RST(a_hold, aclk, aresetn, (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tlast)), "output word changed while stalled")

    // reset leaves the block idle
    `E128M_ASSERT_ALWAYS(a_rst, aclk, !aresetn |=> (s_tready && !m_tvalid), "not idle after reset")

endmodule

bind excess128_to_mulaw_resampler e128m_checker u_e128m_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

// ===== test/tb_excess128_to_mulaw_resampler.sv =====
// ----------------------------------------------------------------------------
// tb_excess128_to_mulaw_resampler
// Self-checking bench for the excess-128 to mu-law resampler. Sample words are
// fed in bursts and every code word is checked against a local mu-law and
// rate-accumulator predictor. The rate increment is swept across several
// settings, including the zero and 20-bit extremes, and the code receiver
// stalls on a pattern of its own, with one long hold-off.
// ----------------------------------------------------------------------------
module tb_excess128_to_mulaw_resampler;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int INC_W      = e128m_pkg::INC_W;
    localparam int ACC_W      = 24;
    localparam int ONE_Q      = 1 << e128m_pkg::FRACTION_BITS;
    localparam int MIN_INC    = ONE_Q >> 6;
    localparam int MAX_REPEAT = e128m_pkg::RUN_CAP;
    localparam int SETTLE     = 8;
    localparam int CYCLE_CAP  = 300000;
    localparam int N_DIRECTED = 20;
    localparam int N_PHASES   = 10;

    typedef struct packed {
        logic [7:0] code;
        logic       last;
    } code_word_t;

    typedef struct packed {
        logic [7:0] sample;
        logic       typed;
        logic [7:0] code;
    } sample_row_t;

    // typed codes: silence, both rails, and the smallest step on either side
    localparam sample_row_t SAMPLE_ROWS [N_DIRECTED] = '{
        '{8'd128, 1'b1, 8'hFF}, '{8'd0,   1'b1, 8'h9F}, '{8'd255, 1'b1, 8'h1F},
        '{8'd127, 1'b1, 8'hF7}, '{8'd129, 1'b1, 8'h77}, '{8'd126, 1'b0, 8'h00},
        '{8'd130, 1'b0, 8'h00}, '{8'd123, 1'b0, 8'h00}, '{8'd122, 1'b0, 8'h00},
        '{8'd134, 1'b0, 8'h00}, '{8'd115, 1'b0, 8'h00}, '{8'd114, 1'b0, 8'h00},
        '{8'd142, 1'b0, 8'h00}, '{8'd99,  1'b0, 8'h00}, '{8'd98,  1'b0, 8'h00},
        '{8'd158, 1'b0, 8'h00}, '{8'd66,  1'b0, 8'h00}, '{8'd190, 1'b0, 8'h00},
        '{8'd3,   1'b0, 8'h00}, '{8'd2,   1'b0, 8'h00}
    };

    logic             aclk;
    logic             aresetn;
    logic             s_tvalid;
    logic             s_tready;
    logic [7:0]       s_tdata;
    logic             m_tvalid;
    logic             m_tready;
    logic [7:0]       m_tdata;
    logic             m_tlast;
    logic             cfg_wr_en;
    logic [INC_W-1:0] cfg_wr_data;

    // predictor state
    logic signed [ACC_W-1:0] acc_q16;
    logic [INC_W-1:0]        rate_inc;
    code_word_t              pending_codes[$];

    code_word_t       got_want;
    logic [INC_W-1:0] phase_rate [N_PHASES];
    int               phase_len  [N_PHASES];
    int               fail_count;
    int               samples_sent;
    int               codes_seen;
    int               rates_used;
    int               run_len;
    int               longest_run;
    int               burst_left;
    int               cycle_count;
    bit               long_hold_done;

    excess128_to_mulaw_resampler u_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    always #5 aclk = ~aclk;

    // segment s spans [top(s-1), top(s)) with top(s) = (64 << s) - 32, step 2 << s
    function automatic logic [7:0] mulaw_of(input logic [7:0] sample);
        logic signed [13:0] lin;
        logic [13:0]        mag;
        logic [13:0]        lo;
        logic [13:0]        hi;
        logic [3:0]         q;
        logic [7:0]         code;
        logic [7:0]         keep;
        bit                 found;
        lin   = 14'sd2048 - $signed({2'b00, sample, 4'b0000});
        mag   = lin[13] ? 14'(-lin) : 14'(lin);
        keep  = lin[13] ? 8'h7F : 8'hFF;
        code  = 8'h80;
        lo    = '0;
        found = 1'b0;
        for (int seg = 0; seg < 8; seg++) begin
            hi = 14'((64 << seg) - 32);
            if (!found && mag < hi) begin
                q     = 4'((mag - lo) / (2 << seg));
                code  = {~4'(seg), ~q};
                found = 1'b1;
            end
            lo = hi;
        end
        return code & keep;
    endfunction

    // step the accumulator for one sample and queue the codes it repeats
    task automatic predict_codes(input logic [7:0] sample, input logic typed,
                                 input logic [7:0] typed_code);
        logic signed [ACC_W-1:0] inc;
        logic [7:0]              code;
        code_word_t              cw;
        int                      n;
        code    = typed ? typed_code : mulaw_of(sample);
        inc     = (rate_inc < INC_W'(MIN_INC)) ? ACC_W'(MIN_INC) : ACC_W'(rate_inc);
        acc_q16 = acc_q16 - ACC_W'(ONE_Q);
        n       = 0;
        while (acc_q16 <= 0 && n < MAX_REPEAT) begin
            acc_q16 = acc_q16 + inc;
            cw.code = code;
            cw.last = (acc_q16 > 0) || (n == MAX_REPEAT - 1);
            pending_codes.push_back(cw);
            n++;
        end
    endtask

    // call at a falling edge; returns at a falling edge with the word taken
    task automatic offer_sample(input logic [7:0] sample, input logic typed,
                                input logic [7:0] typed_code);
        if (burst_left == 0) begin
            s_tvalid = 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge aclk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40)
                                                     : $urandom_range(1, 8);
        end
        s_tvalid = 1'b1;
        s_tdata  = sample;
        do @(posedge aclk); while (!s_tready);
        predict_codes(sample, typed, typed_code);
        samples_sent++;
        burst_left--;
        @(negedge aclk);
    endtask

    // drop valid, wait for every code, then let a dropped word finish
    task automatic drain_codes();
        s_tvalid = 1'b0;
        while (pending_codes.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic set_rate(input logic [INC_W-1:0] value);
        cfg_wr_en   = 1'b1;
        cfg_wr_data = value;
        @(posedge aclk);
        rate_inc = value;
        @(negedge aclk);
        cfg_wr_en = 1'b0;
        rates_used++;
    endtask

    // code receiver: randomly chosen stall modes, one long hold while the sender waits
    initial begin
        int mode;
        int mode_left;
        int hold_left;
        m_tready  = 1'b0;
        mode      = 0;
        mode_left = 0;
        hold_left = 0;
        forever begin
            @(negedge aclk);
            if (!long_hold_done && codes_seen >= 100 && s_tvalid && !s_tready) begin
                long_hold_done = 1'b1;
                hold_left      = 300;
            end
            if (mode_left == 0) begin
                mode      = $urandom_range(0, 2);
                mode_left = $urandom_range(20, 150);
            end
            mode_left--;
            if (hold_left > 0) begin
                m_tready = 1'b0;
                hold_left--;
            end else begin
                case (mode)
                    0: m_tready = 1'b1;
                    1: m_tready = 1'($urandom_range(0, 1));
                    default: m_tready = ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_codes.size() == 0) begin
                $error("unexpected code word 0x%02h, last %0b", m_tdata, m_tlast);
                fail_count++;
            end else begin
                got_want = pending_codes.pop_front();
                if (m_tdata !== got_want.code) begin
                    $error("ulaw_code: expected 0x%02h, got 0x%02h", got_want.code, m_tdata);
                    fail_count++;
                end
                if (m_tlast !== got_want.last) begin
                    $error("last_of_run: expected %0b, got %0b", got_want.last, m_tlast);
                    fail_count++;
                end
            end
            codes_seen++;
            run_len++;
            if (m_tlast) begin
                if (run_len > longest_run) longest_run = run_len;
                run_len = 0;
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_CAP) begin
            $display("excess128_to_mulaw_resampler regression: fail");
            $finish;
        end
    end

    initial begin
        logic [7:0] sample;
        aclk           = 1'b0;
        aresetn        = 1'b0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        cfg_wr_en      = 1'b0;
        cfg_wr_data    = '0;
        fail_count     = 0;
        samples_sent   = 0;
        codes_seen     = 0;
        rates_used     = 0;
        run_len        = 0;
        longest_run    = 0;
        burst_left     = 0;
        cycle_count    = 0;
        long_hold_done = 1'b0;
        acc_q16        = ACC_W'(ONE_Q);
        rate_inc       = INC_W'(90112);

        phase_rate = '{INC_W'(65536), INC_W'(1024), INC_W'(0), INC_W'(1023),
                       INC_W'(524288), {INC_W{1'b1}},
                       INC_W'($urandom_range(1024, 524288)),
                       INC_W'($urandom_range(1024, 524288)),
                       INC_W'($urandom), INC_W'(90112)};
        phase_len  = '{24, 6, 4, 3, 24, 20, 20, 20, 12, 7};

        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // directed samples at the reset increment
        for (int i = 0; i < N_DIRECTED; i++)
            offer_sample(SAMPLE_ROWS[i].sample, SAMPLE_ROWS[i].typed, SAMPLE_ROWS[i].code);
        drain_codes();

        for (int p = 0; p < N_PHASES; p++) begin
            set_rate(phase_rate[p]);
            for (int i = 0; i < phase_len[p]; i++) begin
                case ($urandom_range(0, 9))
                    0: sample = 8'd0;
                    1: sample = 8'd255;
                    2: sample = 8'd128;
                    default: sample = 8'($urandom_range(0, 255));
                endcase
                offer_sample(sample, 1'b0, 8'h00);
            end
            drain_codes();
        end

        $display("covered %0d samples over %0d rate settings plus reset default",
                 samples_sent, rates_used);
        $display("checked %0d code words, longest repeat run %0d", codes_seen, longest_run);
        if (fail_count == 0) begin
            $display("excess128_to_mulaw_resampler regression: pass");
        end else begin
            $display("excess128_to_mulaw_resampler regression: fail");
        end
        $finish;
    end

endmodule
